>>> sv/can_frame_tx_rx_fifo_pair_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the CAN frame queue pair
// Shared property wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef CAN_FRAME_TX_RX_FIFO_PAIR_TOP_ASSERT_SVH
`define CAN_FRAME_TX_RX_FIFO_PAIR_TOP_ASSERT_SVH

// same-cycle implication
`define CFMQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/cfmq_pkg.sv
// ----------------------------------------------------------------------------
// CAN frame queue pair package
// Widths, operation and status codes, entry types and payload helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfmq_pkg;

  localparam int QUEUE_SLOTS = 128;
  localparam int PTR_W       = $clog2(QUEUE_SLOTS);
  localparam int BYTES       = 8;

  localparam int KIND_W   = 3;
  localparam int ID_W     = 32;
  localparam int DLC_W    = 4;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 32;

  localparam logic [KIND_W-1:0] KIND_SEND    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELIVER = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FETCH   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FLUSH   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RESTART = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_PASSIVE = 2'd3;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DLC_W-1:0]  dlc;
    logic [DATA_W-1:0] data;
  } frame_t;

  localparam int FRAME_W = $bits(frame_t);

  typedef struct packed {
    logic              we;
    ptr_t              waddr;
    frame_t            wdata;
    logic              re;
    ptr_t              raddr;
  } mem_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     frame_id;
    logic [DLC_W-1:0]    frame_dlc;
    logic [DATA_W-1:0]   frame_data;
    logic [CNT_W-1:0]    tx_overruns;
    logic [CNT_W-1:0]    rx_overruns;
  } result_t;

  function automatic ptr_t next_slot(input ptr_t p);
    return (p == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  // zero every byte at or above the length code
  function automatic logic [DATA_W-1:0] keep_valid_bytes(input logic [DATA_W-1:0] d,
                                                          input logic [DLC_W-1:0] len);
    logic [DATA_W-1:0] r;
    r = '0;
    for (int i = 0; i < BYTES; i++) begin
      if (len > DLC_W'(i)) begin
        r[i*8 +: 8] = d[i*8 +: 8];
      end
    end
    return r;
  endfunction

endpackage

>>> sv/cfmq_if.sv
// ----------------------------------------------------------------------------
// CAN frame queue pair channel interfaces
// Request, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cfmq_req_if import cfmq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   identifier;
  logic [DLC_W-1:0]  dlc;
  logic [DATA_W-1:0] data;

  modport source (output valid, kind, identifier, dlc, data, input ready);
  modport sink   (input valid, kind, identifier, dlc, data, output ready);
endinterface

interface cfmq_rsp_if import cfmq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     frame_id;
  logic [DLC_W-1:0]    frame_dlc;
  logic [DATA_W-1:0]   frame_data;
  logic [CNT_W-1:0]    tx_overruns;
  logic [CNT_W-1:0]    rx_overruns;

  modport source (output valid, status, frame_id, frame_dlc, frame_data,
                  tx_overruns, rx_overruns, input ready);
  modport sink   (input valid, status, frame_id, frame_dlc, frame_data,
                  tx_overruns, rx_overruns, output ready);
endinterface

interface cfmq_cfg_if import cfmq_pkg::*; ();
  logic valid;
  logic ready;
  logic bus_active;

  modport source (output valid, bus_active, input ready);
  modport sink   (input valid, bus_active, output ready);
endinterface

>>> sv/cfmq_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfmq_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/cfmq_ctrl.sv
// ----------------------------------------------------------------------------
// CAN frame queue pair controller
// Ring pointers, overrun counters, bus flag and memory sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "can_frame_tx_rx_fifo_pair_top_assert.svh"

module cfmq_ctrl import cfmq_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  cfmq_req_if.sink        req,
  cfmq_cfg_if.sink        cfg,
  input  logic            out_free,
  output logic            res_load,
  output result_t         res,
  output mem_req_t        tx_req,
  output mem_req_t        rx_req,
  input  frame_t          tx_rdata,
  input  frame_t          rx_rdata
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic             state, state_next;
  logic             pend_rx, pend_rx_next;
  logic             bus_active, bus_active_next;
  ptr_t             tx_wr, tx_wr_next, tx_rd, tx_rd_next;
  ptr_t             rx_wr, rx_wr_next, rx_rd, rx_rd_next;
  logic [CNT_W-1:0] tx_drop, tx_drop_next, rx_drop, rx_drop_next;

  logic   acc;
  logic   tx_full, tx_empty, rx_full, rx_empty;
  frame_t rd_frame;

  assign req.ready = (state == S_IDLE) && out_free;
  assign cfg.ready = 1'b1;
  assign acc       = req.valid && req.ready;

  assign tx_full  = (next_slot(tx_wr) == tx_rd);
  assign rx_full  = (next_slot(rx_wr) == rx_rd);
  assign tx_empty = (tx_rd == tx_wr);
  assign rx_empty = (rx_rd == rx_wr);

  assign rd_frame = pend_rx ? rx_rdata : tx_rdata;

  always_comb begin
    state_next      = state;
    pend_rx_next    = pend_rx;
    bus_active_next = bus_active;
    tx_wr_next      = tx_wr;
    tx_rd_next      = tx_rd;
    rx_wr_next      = rx_wr;
    rx_rd_next      = rx_rd;
    tx_drop_next    = tx_drop;
    rx_drop_next    = rx_drop;
    tx_req          = '0;
    rx_req          = '0;
    res             = '0;
    res_load        = 1'b0;

    if (state == S_READ) begin
      // frame arrives from the RAM in the cycle after the read
      res_load       = 1'b1;
      res.status     = ST_DONE;
      res.frame_id   = rd_frame.id;
      res.frame_dlc  = rd_frame.dlc;
      res.frame_data = pend_rx ? keep_valid_bytes(rd_frame.data, rd_frame.dlc)
                               : rd_frame.data;
      state_next     = S_IDLE;
    end else if (acc) begin
      res_load   = 1'b1;
      res.status = ST_DONE;
      unique case (req.kind)
        KIND_SEND: begin
          if (!bus_active) begin
            res.status = ST_PASSIVE;
          end else if (tx_full) begin
            tx_drop_next = tx_drop + CNT_W'(1);
            res.status   = ST_FULL;
          end else begin
            tx_req.we         = 1'b1;
            tx_req.waddr      = tx_wr;
            tx_req.wdata.id   = req.identifier;
            tx_req.wdata.dlc  = req.dlc;
            tx_req.wdata.data = keep_valid_bytes(req.data, req.dlc);
            tx_wr_next        = next_slot(tx_wr);
          end
        end
        KIND_READ: begin
          if (!bus_active) begin
            res.status = ST_PASSIVE;
          end else if (rx_empty) begin
            res.status = ST_EMPTY;
          end else begin
            rx_req.re    = 1'b1;
            rx_req.raddr = rx_rd;
            rx_rd_next   = next_slot(rx_rd);
            pend_rx_next = 1'b1;
            res_load     = 1'b0;
            state_next   = S_READ;
          end
        end
        KIND_DELIVER: begin
          if (rx_full) begin
            rx_drop_next = rx_drop + CNT_W'(1);
            res.status   = ST_FULL;
          end else begin
            rx_req.we         = 1'b1;
            rx_req.waddr      = rx_wr;
            rx_req.wdata.id   = req.identifier;
            rx_req.wdata.dlc  = req.dlc;
            rx_req.wdata.data = req.data;
            rx_wr_next        = next_slot(rx_wr);
          end
        end
        KIND_FETCH: begin
          if (tx_empty) begin
            res.status = ST_EMPTY;
          end else begin
            tx_req.re    = 1'b1;
            tx_req.raddr = tx_rd;
            tx_rd_next   = next_slot(tx_rd);
            pend_rx_next = 1'b0;
            res_load     = 1'b0;
            state_next   = S_READ;
          end
        end
        KIND_FLUSH: begin
          tx_wr_next = '0;
          tx_rd_next = '0;
          rx_wr_next = '0;
          rx_rd_next = '0;
        end
        KIND_RESTART: begin
          tx_wr_next      = '0;
          tx_rd_next      = '0;
          rx_wr_next      = '0;
          rx_rd_next      = '0;
          tx_drop_next    = '0;
          rx_drop_next    = '0;
          bus_active_next = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (cfg.valid) begin
      bus_active_next = cfg.bus_active;
    end

    res.tx_overruns = tx_drop_next;
    res.rx_overruns = rx_drop_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_rx    <= 1'b0;
      bus_active <= 1'b0;
      tx_wr      <= '0;
      tx_rd      <= '0;
      rx_wr      <= '0;
      rx_rd      <= '0;
      tx_drop    <= '0;
      rx_drop    <= '0;
    end else begin
      state      <= state_next;
      pend_rx    <= pend_rx_next;
      bus_active <= bus_active_next;
      tx_wr      <= tx_wr_next;
      tx_rd      <= tx_rd_next;
      rx_wr      <= rx_wr_next;
      rx_rd      <= rx_rd_next;
      tx_drop    <= tx_drop_next;
      rx_drop    <= rx_drop_next;
    end
  end

  `CFMQ_ASSERT_IMPL(a_read_lands, state == S_READ,
                    out_free && res_load && !req.ready, "read result not loaded")
  `CFMQ_ASSERT_NEXT(a_read_enters, tx_req.re || rx_req.re, state == S_READ,
                    "RAM read without read state")
  `CFMQ_ASSERT_NEXT(a_restart_clears, acc && req.kind == KIND_RESTART && !cfg.valid,
                    tx_drop == '0 && rx_drop == '0 && bus_active, "restart left state")
  `CFMQ_ASSERT_NEXT(a_tx_full_drop, acc && req.kind == KIND_SEND && bus_active && tx_full,
                    $stable(tx_wr) && tx_drop == $past(tx_drop) + 32'd1,
                    "full send stored a frame")

endmodule

>>> sv/can_frame_tx_rx_fifo_pair_top.sv
// Results: send, deliver, flush, restart and refused or empty requests load their
// result on acceptance; node read and bus fetch load it from the read state.
// Throughput: 1 item per cycle for writes; a read blocks the next request until its
// frame is back from the registered RAM read port; a stalled result holds requests.
// Reset: synchronous rst empties both queues, clears both counters and bus_active;
// RAM contents are not cleared, so no entry is read before it is written.
// ----------------------------------------------------------------------------
// CAN frame queue pair, top level
// Transmit and receive frame rings in two RAMs with overrun counting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module can_frame_tx_rx_fifo_pair_top import cfmq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cfmq_req_if.sink  req,
  cfmq_rsp_if.source rsp,
  cfmq_cfg_if.sink  cfg
);

  // Controller <-> RAM request bundles, one per queue.
  mem_req_t tx_req, rx_req;
  frame_t   tx_rdata, rx_rdata;

  // Result handoff into the output register.
  logic    res_load;
  result_t res;
  logic    out_free;

  // Output register state.
  logic    out_valid;
  result_t out_res;

  // The output register may take a new item when empty or being drained.
  assign out_free = !out_valid || rsp.ready;

  cfmq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg      (cfg),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res),
    .tx_req   (tx_req),
    .rx_req   (rx_req),
    .tx_rdata (tx_rdata),
    .rx_rdata (rx_rdata)
  );

  // Transmit ring: written by node send, read by bus fetch.
  cfmq_ram #(
    .DEPTH (QUEUE_SLOTS),
    .WIDTH (FRAME_W)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_req.we),
    .waddr (tx_req.waddr),
    .wdata (tx_req.wdata),
    .re    (tx_req.re),
    .raddr (tx_req.raddr),
    .rdata (tx_rdata)
  );

  // Receive ring: written by bus deliver, read by node read.
  cfmq_ram #(
    .DEPTH (QUEUE_SLOTS),
    .WIDTH (FRAME_W)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_req.we),
    .waddr (rx_req.waddr),
    .wdata (rx_req.wdata),
    .re    (rx_req.re),
    .raddr (rx_req.raddr),
    .rdata (rx_rdata)
  );

  // Output register: separates result delivery from request intake.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_res.status;
  assign rsp.frame_id    = out_res.frame_id;
  assign rsp.frame_dlc   = out_res.frame_dlc;
  assign rsp.frame_data  = out_res.frame_data;
  assign rsp.tx_overruns = out_res.tx_overruns;
  assign rsp.rx_overruns = out_res.rx_overruns;

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// CAN frame queue pair testbench
// Drives node and bus requests into the mailbox and checks every reply item
// against a cycle-free model of the two frame rings, overrun counters and
// bus_active. Directed table first, then randomized phases with idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench import cfmq_pkg::*; ();

  // Kinds the block decodes as no-ops
  localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;

  localparam logic [DATA_W-1:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

  // Idle margin after the last reply, before config is written
  localparam int SETTLE_CYCLES = 4;
  // Long receiver hold-off so the request side backs up
  localparam int HOLD_CYCLES   = 400;
  // Cycles with no handshake on any channel before the run is declared hung
  localparam int STALL_LIMIT   = 4000;
  localparam int ITEM_TARGET   = 1500;
  localparam int MIXED_ITEMS   = 120;
  // Slot count plus three, four past capacity, so the full case is hit repeatedly
  localparam int FILL_ITEMS    = QUEUE_SLOTS + 3;

  // Directed stimulus row; 'typed' rows carry a hand-written reply
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [DLC_W-1:0]  dlc;
    logic [DATA_W-1:0] data;
    logic              typed;
    result_t           want;
  } stim_row_t;

  localparam result_t REPLY_DONE    = '{ST_DONE, '0, '0, '0, '0, '0};
  localparam result_t REPLY_EMPTY   = '{ST_EMPTY, '0, '0, '0, '0, '0};
  localparam result_t REPLY_PASSIVE = '{ST_PASSIVE, '0, '0, '0, '0, '0};
  localparam result_t REPLY_NONE    = '0;

  localparam int DIRECTED_ROWS = 27;

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Out of reset the bus is inactive: node requests are refused
    '{KIND_SEND,    32'h0000_0001, 4'd8,  64'h1122_3344_5566_7788, 1'b1, REPLY_PASSIVE},
    '{KIND_READ,    32'h0,         4'd0,  64'h0,                   1'b1, REPLY_PASSIVE},
    // Bus side ignores bus_active
    '{KIND_FETCH,   32'h0,         4'd0,  64'h0,                   1'b1, REPLY_EMPTY},
    '{KIND_DELIVER, 32'hFFFF_FFFF, 4'd15, ONES64,                  1'b1, REPLY_DONE},
    // Spare kinds do nothing
    '{KIND_RSVD6,   32'h0,         4'd0,  64'h0,                   1'b1, REPLY_DONE},
    '{KIND_RSVD7,   32'hFFFF_FFFF, 4'd15, ONES64,                  1'b1, REPLY_DONE},
    '{KIND_FETCH,   32'h0,         4'd0,  64'h0,                   1'b1, REPLY_EMPTY},
    // Restart drops the delivered frame and turns the bus on
    '{KIND_RESTART, 32'h0,         4'd0,  64'h0,                   1'b1, REPLY_DONE},
    // Node read zero-fills bytes at or above the stored length code
    '{KIND_DELIVER, 32'h0,         4'd0,  ONES64,                  1'b0, REPLY_NONE},
    '{KIND_READ,    32'h0,         4'd0,  64'h0,                   1'b0, REPLY_NONE},
    '{KIND_DELIVER, 32'hFFFF_FFFF, 4'd15, ONES64,                  1'b0, REPLY_NONE},
    '{KIND_READ,    32'h0,         4'd0,  64'h0,                   1'b0, REPLY_NONE},
    '{KIND_DELIVER, 32'h1234_5678, 4'd7,  64'h0123_4567_89AB_CDEF, 1'b0, REPLY_NONE},
    '{KIND_READ,    32'h0,         4'd0,  64'h0,                   1'b0, REPLY_NONE},
    // Node send trims the payload, fetch carries it as stored
    '{KIND_SEND,    32'hFFFF_FFFF, 4'd15, ONES64,                  1'b0, REPLY_NONE},
    '{KIND_SEND,    32'h0,         4'd0,  ONES64,                  1'b0, REPLY_NONE},
    '{KIND_SEND,    32'h0BAD_CAFE, 4'd3,  64'hA5A5_A5A5_A5A5_A5A5, 1'b0, REPLY_NONE},
    '{KIND_SEND,    32'h0000_07FF, 4'd8,  64'h8877_6655_4433_2211, 1'b0, REPLY_NONE},
    '{KIND_FETCH,   32'h0,         4'd0,  64'h0,                   1'b0, REPLY_NONE},
    '{KIND_FETCH,   32'h0,         4'd0,  64'h0,                   1'b0, REPLY_NONE},
    '{KIND_FETCH,   32'h0,         4'd0,  64'h0,                   1'b0, REPLY_NONE},
    '{KIND_FETCH,   32'h0,         4'd0,  64'h0,                   1'b0, REPLY_NONE},
    // Flush empties both rings
    '{KIND_SEND,    32'h0000_0055, 4'd2,  ONES64,                  1'b0, REPLY_NONE},
    '{KIND_DELIVER, 32'h0000_00AA, 4'd5,  ONES64,                  1'b0, REPLY_NONE},
    '{KIND_FLUSH,   32'h0,         4'd0,  64'h0,                   1'b0, REPLY_NONE},
    '{KIND_FETCH,   32'h0,         4'd0,  64'h0,                   1'b0, REPLY_NONE},
    '{KIND_READ,    32'h0,         4'd0,  64'h0,                   1'b0, REPLY_NONE}
  };

  logic clk;
  logic rst;

  cfmq_req_if req_ch ();
  cfmq_rsp_if rsp_ch ();
  cfmq_cfg_if cfg_ch ();

  can_frame_tx_rx_fifo_pair_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // --------------------------------------------------------------------------
  // Mailbox model state: two rings of QUEUE_SLOTS entries, one slot kept free
  // --------------------------------------------------------------------------
  frame_t           tx_ring [QUEUE_SLOTS];
  frame_t           rx_ring [QUEUE_SLOTS];
  ptr_t             tx_wr = '0;
  ptr_t             tx_rd = '0;
  ptr_t             rx_wr = '0;
  ptr_t             rx_rd = '0;
  logic [CNT_W-1:0] tx_drops = '0;
  logic [CNT_W-1:0] rx_drops = '0;
  logic             node_enabled = 1'b0;

  // Replies owed by the block, oldest first
  result_t replies_due [$];

  int  items_sent;
  int  mismatch_count;
  int  sender_idle_pct;
  int  receiver_stall_pct;
  bit  hold_off_request;
  int  quiet_cycles;

  function automatic ptr_t ring_advance(input ptr_t p);
    return (p == ptr_t'(QUEUE_SLOTS - 1)) ? ptr_t'(0) : ptr_t'(p + 1);
  endfunction

  // Bytes with index >= len are cleared; len of 8 or more keeps everything
  function automatic logic [DATA_W-1:0] trim_payload(input logic [DATA_W-1:0] d,
                                                     input logic [DLC_W-1:0] len);
    if (len >= 4'd8) return d;
    return d & ((64'd1 << (8 * len)) - 64'd1);
  endfunction

  // One request in, one reply out; updates the model state
  function automatic result_t mailbox_predict(input logic [KIND_W-1:0] kind,
                                              input logic [ID_W-1:0]   id,
                                              input logic [DLC_W-1:0]  dlc,
                                              input logic [DATA_W-1:0] data);
    result_t r;
    ptr_t    nxt;
    frame_t  f;
    r = '0;
    r.status = ST_DONE;
    unique case (kind)
      KIND_SEND: begin
        if (!node_enabled) begin
          r.status = ST_PASSIVE;
        end else begin
          nxt = ring_advance(tx_wr);
          if (nxt == tx_rd) begin
            tx_drops = tx_drops + CNT_W'(1);
            r.status = ST_FULL;
          end else begin
            tx_ring[tx_wr] = '{id, dlc, trim_payload(data, dlc)};
            tx_wr = nxt;
          end
        end
      end
      KIND_READ: begin
        if (!node_enabled) begin
          r.status = ST_PASSIVE;
        end else if (rx_rd == rx_wr) begin
          r.status = ST_EMPTY;
        end else begin
          f = rx_ring[rx_rd];
          r.frame_id   = f.id;
          r.frame_dlc  = f.dlc;
          r.frame_data = trim_payload(f.data, f.dlc);
          rx_rd = ring_advance(rx_rd);
        end
      end
      KIND_DELIVER: begin
        nxt = ring_advance(rx_wr);
        if (nxt == rx_rd) begin
          rx_drops = rx_drops + CNT_W'(1);
          r.status = ST_FULL;
        end else begin
          rx_ring[rx_wr] = '{id, dlc, data};
          rx_wr = nxt;
        end
      end
      KIND_FETCH: begin
        if (tx_rd == tx_wr) begin
          r.status = ST_EMPTY;
        end else begin
          f = tx_ring[tx_rd];
          r.frame_id   = f.id;
          r.frame_dlc  = f.dlc;
          r.frame_data = f.data;
          tx_rd = ring_advance(tx_rd);
        end
      end
      KIND_FLUSH: begin
        tx_wr = '0; tx_rd = '0; rx_wr = '0; rx_rd = '0;
      end
      KIND_RESTART: begin
        tx_wr = '0; tx_rd = '0; rx_wr = '0; rx_rd = '0;
        tx_drops = '0;
        rx_drops = '0;
        node_enabled = 1'b1;
      end
      default: begin
      end
    endcase
    r.tx_overruns = tx_drops;
    r.rx_overruns = rx_drops;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Request driver. Called right after a rising edge; returns right after the
  // edge that accepted the item, possibly after an idle gap. valid is only
  // lowered when a gap is taken, so it is never dropped and raised in one step.
  // --------------------------------------------------------------------------
  task automatic offer_item(input logic [KIND_W-1:0] kind,
                            input logic [ID_W-1:0]   id,
                            input logic [DLC_W-1:0]  dlc,
                            input logic [DATA_W-1:0] data,
                            input logic              typed,
                            input result_t           want);
    result_t predicted;
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= kind;
    req_ch.identifier <= id;
    req_ch.dlc        <= dlc;
    req_ch.data       <= data;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // accepted at this edge
    predicted = mailbox_predict(kind, id, dlc, data);
    replies_due.push_back(typed ? want : predicted);
    items_sent++;
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  task automatic offer_random(input logic [KIND_W-1:0] kind);
    offer_item(kind, $urandom, 4'($urandom_range(15)), {$urandom, $urandom},
               1'b0, REPLY_NONE);
  endtask

  // Stop offering and wait until every reply is back, then let the pipe drain
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle
  task automatic write_bus_active(input logic value);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.bus_active <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    node_enabled = value;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int phase;
    int pick;
    req_ch.valid      <= 1'b0;
    req_ch.kind       <= KIND_FLUSH;
    req_ch.identifier <= '0;
    req_ch.dlc        <= '0;
    req_ch.data       <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.bus_active <= 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_request   = 1'b0;
    items_sent         = 0;
    mismatch_count     = 0;
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table, no idling
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      offer_item(DIRECTED[i].kind, DIRECTED[i].id, DIRECTED[i].dlc,
                 DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Randomized phases. Each starts idle, rewrites bus_active (mostly on,
    // every third phase off), picks an idling mode and a traffic shape.
    phase = 0;
    while (items_sent < ITEM_TARGET + DIRECTED_ROWS) begin
      settle();
      write_bus_active((phase % 3 == 2) ? 1'b0 : 1'b1);
      unique case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
        default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
      endcase
      unique case (phase % 5)
        1: begin
          // Transmit ring past full, then drain it. The first time round the
          // receiver holds off so the block backs up onto the request side.
          if (phase == 1) hold_off_request = 1'b1;
          repeat (FILL_ITEMS) offer_random(KIND_SEND);
          repeat (FILL_ITEMS) offer_random(KIND_FETCH);
        end
        3: begin
          // Receive ring past full, then drain it
          repeat (FILL_ITEMS) offer_random(KIND_DELIVER);
          repeat (FILL_ITEMS) offer_random(KIND_READ);
        end
        default: begin
          // Mixed traffic; flush and restart kept rare so the rings fill a bit
          repeat (MIXED_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 25)      offer_random(KIND_SEND);
            else if (pick < 45) offer_random(KIND_READ);
            else if (pick < 70) offer_random(KIND_DELIVER);
            else if (pick < 90) offer_random(KIND_FETCH);
            else if (pick < 94) offer_random(KIND_FLUSH);
            else if (pick < 97) offer_random(KIND_RESTART);
            else offer_random($urandom_range(1) ? KIND_RSVD6 : KIND_RSVD7);
          end
        end
      endcase
      phase++;
    end

    settle();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Reply side ready: random stalls per phase, plus the one long hold-off
  // --------------------------------------------------------------------------
  initial begin : reply_ready
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_request = 1'b0;
      end
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Reply checker: each accepted reply against the oldest one owed
  // --------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_replies
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (replies_due.size() == 0) begin
        $error("reply item with none outstanding");
        mismatch_count++;
      end else begin
        want = replies_due.pop_front();
        compare_field("status",      64'(want.status),      64'(rsp_ch.status));
        compare_field("frame_id",    64'(want.frame_id),    64'(rsp_ch.frame_id));
        compare_field("frame_dlc",   64'(want.frame_dlc),   64'(rsp_ch.frame_dlc));
        compare_field("frame_data",  want.frame_data,       rsp_ch.frame_data);
        compare_field("tx_overruns", 64'(want.tx_overruns), 64'(rsp_ch.tx_overruns));
        compare_field("rx_overruns", 64'(want.rx_overruns), 64'(rsp_ch.rx_overruns));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with no handshake on any channel means a hang
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

>>> can_frame_tx_rx_fifo_pair_top.f
+incdir+sv
sv/cfmq_pkg.sv
sv/cfmq_if.sv
sv/cfmq_ram.sv
sv/cfmq_ctrl.sv
sv/can_frame_tx_rx_fifo_pair_top.sv
sim/testbench.sv
